// ===== rtl/gdbp_pkg.sv =====
// Shared types and constants for the gamma dither bit packer.
package gdbp_pkg;

  localparam int unsigned ERR_W = 18;   // signed Q1.16 error word
  localparam int unsigned SUM_W = 22;   // weighted error sum, signed
  localparam int unsigned DOT_W = 17;   // Q1.16 intensity, 65536 = 1.0
  localparam int unsigned GAM_W = 12;   // gamma strength, unsigned Q4.8
  localparam int unsigned DPR_W = 13;   // dots_per_row register
  localparam int unsigned CFG_W = 13;   // widest configuration register
  localparam int unsigned IDX_W = 2;    // configuration register index

  localparam logic [DOT_W-1:0] DOT_ONE = 17'd65536;
  localparam logic signed [ERR_W-1:0] ERR_HALF = 18'sd32768;
  localparam logic signed [SUM_W-1:0] SUM_HALF = 22'sd32768;
  localparam logic signed [SUM_W-1:0] SUM_ONE = 22'sd65536;

  localparam logic [IDX_W-1:0] REG_DOTS_PER_ROW = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAMMA = 2'd1;
  localparam logic [IDX_W-1:0] REG_INVERT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } top_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_INIT,
    DV_RUN
  } div_state_t;

  // Command from the dither sequencer to the packer.
  typedef struct packed {
    logic clear;   // drop any partial byte (image start)
    logic push;    // append one dot
    logic dot;     // dithered bit
    logic last;    // dot ends the row
  } pack_cmd_t;

endpackage

// ===== rtl/gdbp_gamma_div.sv =====
// Gamma curve unit: one multiply, then a restoring radix-2 divider.
module gdbp_gamma_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gdbp_pkg::DOT_W-1:0]  dot,
  input  logic [gdbp_pkg::GAM_W-1:0]  gamma,
  output logic                        done,
  output logic [gdbp_pkg::DOT_W-1:0]  quot
);
  import gdbp_pkg::*;

  localparam int unsigned GP_W = GAM_W + DOT_W;   // g*p
  localparam int unsigned NUM_W = GP_W + 1;       // (256+g)*p
  localparam int unsigned CNT_W = $clog2(DOT_W);

  div_state_t state, state_next;

  logic [DOT_W-1:0] p_r;
  logic [GAM_W-1:0] g_r;
  logic [GP_W-1:0]  gp;
  logic [GP_W-1:0]  den;
  logic [GP_W-1:0]  rem;
  logic             low_bit;
  logic [CNT_W-1:0] cnt;

  logic [NUM_W-1:0] num_hi;
  logic [NUM_W-1:0] trial;
  logic             fits;

  // (256+g)*p = p*256 + g*p; the 65536 factor shows up as sixteen zero bits fed in
  assign num_hi = {{(NUM_W-DOT_W-8){1'b0}}, p_r, 8'b0} + {1'b0, gp};
  assign trial  = {rem, (cnt == '0) ? low_bit : 1'b0};
  assign fits   = trial >= {1'b0, den};

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: if (start) state_next = DV_MUL;
      DV_MUL:  state_next = DV_INIT;
      DV_INIT: state_next = DV_RUN;
      DV_RUN:  if (cnt == CNT_W'(DOT_W-1)) state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DV_RUN) && (cnt == CNT_W'(DOT_W-1));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          p_r <= dot;
          g_r <= gamma;
        end
      end
      DV_MUL: begin
        gp <= g_r * p_r;
      end
      DV_INIT: begin
        // quotient fits in DOT_W bits, so the top part starts below the divisor
        den     <= GP_W'(1 << 24) + gp;
        rem     <= num_hi[NUM_W-1:1];
        low_bit <= num_hi[0];
        cnt     <= '0;
        quot    <= '0;
      end
      DV_RUN: begin
        rem  <= fits ? GP_W'(trial - {1'b0, den}) : trial[GP_W-1:0];
        quot <= {quot[DOT_W-2:0], fits};
        cnt  <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/gdbp_packer.sv =====
// Packs dithered dots MSB first into bytes and holds the output beat.
module gdbp_packer (
  input  logic                  clk,
  input  logic                  rst,
  input  gdbp_pkg::pack_cmd_t   cmd,
  output logic                  can_push,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            packed_dots,
  output logic                  row_end
);
  import gdbp_pkg::*;

  logic [7:0] acc;
  logic [2:0] held;
  logic [7:0] acc_next;
  logic [7:0] pad;
  logic       emit;

  assign can_push = !out_valid || out_ready;
  assign acc_next = acc | ({7'b0, cmd.dot} << (3'd7 - held));
  // ones below the new dot fill out a short row
  assign pad      = 8'hFF >> ({1'b0, held} + 4'd1);
  assign emit     = cmd.push && (cmd.last || (held == 3'd7));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new byte replaces the one taken in the same cycle
      if (emit && !cmd.clear) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        acc  <= '0;
        held <= '0;
      end else if (emit) begin
        acc  <= '0;
        held <= '0;
      end else if (cmd.push) begin
        acc  <= acc_next;
        held <= held + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packed_dots <= cmd.last ? (acc_next | pad) : acc_next;
      row_end     <= cmd.last;
    end
  end

endmodule

// ===== rtl/gamma_dither_bit_packer.sv =====
// Top level: gamma correction, Floyd-Steinberg dither and MSB-first bit packing.
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ---------------------------------
//  in       input      in_valid / in_ready    intensity[16:0], image_start
//  out      output     out_valid / out_ready  packed_dots[7:0], row_end
//  cfg      input      cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[12:0]
//
//  Each dot passes through acceptance, one multiply, one divider set-up,
//  17 restoring divide steps, the quotient hand-over, and a final step that
//  dithers and packs it. The error write lands in that final step; in_ready
//  is low from acceptance until the error write.
//  Reset (synchronous, rst high) restores register defaults and starts a
//  fresh image; the error line itself is not cleared. The finishing cycle
//  holds while an earlier byte is still waiting on out_ready.
//  cfg_ready is always high.
module gamma_dither_bit_packer #(
  parameter int unsigned MAX_DOTS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gdbp_pkg::DOT_W-1:0]  intensity,
  input  logic                        image_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  packed_dots,
  output logic                        row_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gdbp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gdbp_pkg::CFG_W-1:0]  cfg_data
);
  import gdbp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DOTS);       // column index
  localparam int unsigned NW = $clog2(MAX_DOTS + 1);   // row length

  // configuration registers
  logic [DPR_W-1:0] dots_per_row;
  logic [GAM_W-1:0] gamma_q4_8;
  logic             invert;

  // dither state
  top_state_t state, state_next;
  logic signed [ERR_W-1:0] error_line [MAX_DOTS];
  logic signed [ERR_W-1:0] above_rd;
  logic signed [ERR_W-1:0] upright_rd;
  logic signed [ERR_W-1:0] left_error;
  logic signed [ERR_W-1:0] upper_left_error;
  logic                    above_valid;
  logic [AW-1:0]           column_position;
  logic                    last;

  // control
  logic            accept;
  logic            fin_go;
  logic            pk_ready;
  logic            div_done;
  logic [DOT_W-1:0] q;
  pack_cmd_t       cmd;

  // per-dot combinational values
  logic [NW-1:0]    row_len;
  logic [AW-1:0]    col_base;
  logic [AW-1:0]    col_use;
  logic [DOT_W-1:0] p_sat;
  logic [DOT_W-1:0] p_eff;
  logic [AW-1:0]    col_plus;

  logic signed [ERR_W-1:0] above;
  logic signed [ERR_W-1:0] upright;
  logic signed [SUM_W-1:0] l_x, ul_x, a_x, ur_x;
  logic signed [SUM_W-1:0] wsum;
  logic signed [SUM_W-1:0] t_raw;
  logic                    dot_bit;
  logic signed [ERR_W-1:0] t_store;

  assign cfg_ready = 1'b1;

  // configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      dots_per_row <= DPR_W'(4096);
      gamma_q4_8   <= '0;
      invert       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DOTS_PER_ROW: dots_per_row <= cfg_data[DPR_W-1:0];
        REG_GAMMA:        gamma_q4_8   <= cfg_data[GAM_W-1:0];
        REG_INVERT:       invert       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp the row length to 1..MAX_DOTS
  always_comb begin
    if (dots_per_row == '0) begin
      row_len = NW'(1);
    end else if (32'(dots_per_row) > 32'(MAX_DOTS)) begin
      row_len = NW'(MAX_DOTS);
    end else begin
      row_len = NW'(dots_per_row);
    end
  end

  // image start restarts at column 0; a shrunken row ends at its last column
  assign col_base = image_start ? '0 : column_position;
  assign col_use  = (NW'(col_base) >= row_len) ? AW'(row_len - NW'(1)) : col_base;

  assign p_sat = (intensity > DOT_ONE) ? DOT_ONE : intensity;
  assign p_eff = invert ? DOT_W'(DOT_ONE - p_sat) : p_sat;

  // state machine: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_CALC;
      ST_CALC: if (div_done) state_next = ST_FIN;
      ST_FIN:  if (pk_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_ready = 1'b0;
    fin_go   = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_CALC: ;
      ST_FIN:  fin_go = pk_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  gdbp_gamma_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .dot   (p_eff),
    .gamma (gamma_q4_8),
    .done  (div_done),
    .quot  (q)
  );

  // row above: read both neighbours every cycle; data settles long before finish
  assign col_plus = column_position + AW'(1);

  always_ff @(posedge clk) begin
    above_rd   <= error_line[column_position];
    upright_rd <= error_line[col_plus];
    if (fin_go) error_line[column_position] <= t_store;
  end

  // weighted error: 7 left, 1 upper-left, 5 above, 3 upper-right, in sixteenths
  assign above   = above_valid ? above_rd : ERR_HALF;
  assign upright = (above_valid && !last) ? upright_rd : ERR_HALF;

  assign l_x  = SUM_W'(left_error);
  assign ul_x = SUM_W'(upper_left_error);
  assign a_x  = SUM_W'(above);
  assign ur_x = SUM_W'(upright);

  assign wsum    = (l_x <<< 3) - l_x + ul_x + (a_x <<< 2) + a_x + (ur_x <<< 1) + ur_x;
  assign t_raw   = $signed({{(SUM_W-DOT_W){1'b0}}, q}) + (wsum >>> 4);
  assign dot_bit = t_raw > SUM_HALF;
  assign t_store = dot_bit ? ERR_W'(t_raw - SUM_ONE) : ERR_W'(t_raw);

  // dither state: image start on accept, advance on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      above_valid      <= 1'b0;
      column_position  <= '0;
      left_error       <= ERR_HALF;
      upper_left_error <= ERR_HALF;
    end else if (accept) begin
      if (image_start) begin
        above_valid      <= 1'b0;
        left_error       <= ERR_HALF;
        upper_left_error <= ERR_HALF;
      end
      column_position <= col_use;
    end else if (fin_go) begin
      if (last) begin
        above_valid      <= 1'b1;
        column_position  <= '0;
        left_error       <= ERR_HALF;
        upper_left_error <= ERR_HALF;
      end else begin
        column_position  <= col_plus;
        left_error       <= t_store;
        upper_left_error <= above;
      end
    end
  end

  // last-column flag for the dot in flight
  always_ff @(posedge clk) begin
    if (accept) last <= (NW'(col_use) + NW'(1)) >= row_len;
  end

  always_comb begin
    cmd.clear = accept && image_start;
    cmd.push  = fin_go;
    cmd.dot   = dot_bit;
    cmd.last  = last;
  end

  gdbp_packer u_pack (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .can_push    (pk_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_dots (packed_dots),
    .row_end     (row_end)
  );

endmodule
